### src/oversampled_serial_frame_receiver_core_assert.svh
// Assertion macros shared by the frame receiver modules.
`ifndef OVERSAMPLED_SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH
`define OVERSAMPLED_SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a condition on every rising clock edge outside reset.
`define OSFR_ASSERT(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// Check that a condition implies another one in the same cycle.
`define OSFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define OSFR_ASSERT(lbl, clk, rstn, expr, msg)
`define OSFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### src/osfr_pkg.sv
// Types and constants of the oversampled serial frame receiver.
package osfr_pkg;

  localparam int DATA_BITS      = 8;
  localparam int MIN_PERIOD     = 30;
  localparam int SAMPLE_STEP_MS = 10;  // ms between two line samples
  localparam int EDGE_WINDOW    = 10;  // residues above this are far from a bit edge
  localparam int ROUND_HALF     = 10;  // remainder of x/20 above this rounds up
  localparam int DIV_TWENTY     = 20;
  localparam int RECIP_20       = 205; // 205 / 4096 ~ 1 / 20, exact for 8 bit values
  localparam int RECIP_SHIFT    = 12;
  localparam int START_SAMPLES  = 3;
  localparam int RUN_MAX        = 255;

  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_SET_IDLE = 2'd1;
  localparam logic [1:0] ACT_CLR_IDLE = 2'd2;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic REG_PERIOD_MS = 1'b0;
  localparam logic REG_SYNC_RUN  = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT_IDLE,
    PH_WAIT_START,
    PH_SAMPLE,
    PH_STOP
  } phase_e;

  typedef enum logic {
    TOP_IDLE,
    TOP_CHECK
  } top_state_e;

  typedef enum logic [2:0] {
    CK_IDLE,
    CK_SCAN,
    CK_PREP,
    CK_ADD,
    CK_RD,
    CK_BIT,
    CK_DONE
  } ck_state_e;

  typedef struct packed {
    logic [1:0] action;
    logic       line_sample;
  } in_req_t;

  typedef struct packed {
    logic [1:0] frame_status;
    logic       byte_ready;
    logic [7:0] received_byte;
  } out_rsp_t;

  typedef struct packed {
    logic       done;
    logic       ok;
    logic [7:0] data;
  } chk_res_t;

endpackage

### src/oversampled_serial_frame_receiver_core.sv
// Top level of the oversampled serial frame receiver: capture control and result register.
// Sequence: the tick that closes a frame waits for the sample scan, one read a cycle over
//   frame_len = min(max(period, MIN_PERIOD) - 1, MAX_SAMPLE_DEPTH) samples, and then for
//   the bit-by-bit byte assembly, which is skipped if the scan fails.
// Throughput: one request per cycle unless the result is held or a frame is being checked.
// Reset: asynchronous, active low; no clearing pass, the capture fill count masks the store.
`include "oversampled_serial_frame_receiver_core_assert.svh"
module oversampled_serial_frame_receiver_core
  import osfr_pkg::*;
#(
  parameter int MAX_SAMPLE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_req_t    in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_rsp_t   out_rsp_o
);

  localparam int AW    = $clog2(MAX_SAMPLE_DEPTH);
  localparam int CNT_W = $clog2(MAX_SAMPLE_DEPTH + 1);
  localparam int LW    = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [LW-1:0] DEPTH_L = LW'(MAX_SAMPLE_DEPTH);

  // configuration
  logic [7:0]       period_q, idle_cnt_q;

  // receiver state
  top_state_e       state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] sample_idx_q, sample_idx_d, idx_inc;
  logic [7:0]       idle_run_q, idle_run_d, busy_run_q, busy_run_d;
  logic             forced_q, forced_d;
  logic [1:0]       status_q, status_d;
  logic [7:0]       byte_q, byte_d;
  logic             out_valid_q, out_valid_d;
  out_rsp_t         out_rsp_q, out_rsp_d;

  logic [7:0]       p_eff, p_m1;
  logic [LW-1:0]    frame_len;
  logic             accept, load_out, byte_rdy, chk_start;

  logic             ram_we, ram_re, ram_rdata;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  chk_res_t         chk_res;

  // short periods clamp to the minimum; long frames clamp to the store depth
  assign p_eff     = (period_q < 8'(MIN_PERIOD)) ? 8'(MIN_PERIOD) : period_q;
  assign p_m1      = p_eff - 8'd1;
  assign frame_len = (LW'(p_m1) > DEPTH_L) ? DEPTH_L : LW'(p_m1);
  assign idx_inc   = sample_idx_q + CNT_W'(1);

  // accept while the result register is free or draining this cycle
  assign in_ready_o = (state_q == TOP_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  osfr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SAMPLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_req_i.line_sample),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  osfr_check #(
    .MAX_SAMPLE_DEPTH (MAX_SAMPLE_DEPTH)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (chk_start),
    .period_i    (p_eff),
    .frame_len_i (frame_len),
    .fill_i      (sample_idx_q),
    .rd_en_o     (ram_re),
    .rd_addr_o   (ram_raddr),
    .rd_data_i   (ram_rdata),
    .res_o       (chk_res)
  );

  // configuration registers; the user must write them only between requests, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= 8'd100;
      idle_cnt_q <= 8'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD_MS: period_q   <= cfg_wdata_i;
        REG_SYNC_RUN:  idle_cnt_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= TOP_IDLE;
      phase_q      <= PH_WAIT_IDLE;
      sample_idx_q <= '0;
      idle_run_q   <= '0;
      busy_run_q   <= '0;
      forced_q     <= 1'b1;
      status_q     <= ST_NONE;
      byte_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      sample_idx_q <= sample_idx_d;
      idle_run_q   <= idle_run_d;
      busy_run_q   <= busy_run_d;
      forced_q     <= forced_d;
      status_q     <= status_d;
      byte_q       <= byte_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    sample_idx_d = sample_idx_q;
    idle_run_d   = idle_run_q;
    busy_run_d   = busy_run_q;
    forced_d     = forced_q;
    status_d     = status_q;
    byte_d       = byte_q;
    load_out     = 1'b0;
    byte_rdy     = 1'b0;
    chk_start    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = AW'(sample_idx_q);

    case (state_q)
      TOP_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (in_req_i.action)
            ACT_SET_IDLE, ACT_CLR_IDLE: begin
              busy_run_d = '0;
              idle_run_d = '0;
              forced_d   = (in_req_i.action == ACT_SET_IDLE);
            end
            ACT_TICK: begin
              case (phase_q)
                PH_WAIT_START: begin
                  // first high sample opens the frame at store entry zero
                  if (in_req_i.line_sample) begin
                    ram_we       = 1'b1;
                    ram_waddr    = '0;
                    sample_idx_d = CNT_W'(1);
                    phase_d      = PH_SAMPLE;
                    forced_d     = 1'b0;
                    status_d     = ST_NONE;
                  end
                end
                PH_SAMPLE: begin
                  ram_we       = (LW'(sample_idx_q) < DEPTH_L);
                  sample_idx_d = idx_inc;
                  if (LW'(idx_inc) >= frame_len) begin
                    phase_d = PH_STOP;
                  end
                end
                PH_STOP: begin
                  // hold the result until the checker reports
                  load_out  = 1'b0;
                  chk_start = 1'b1;
                  state_d   = TOP_CHECK;
                end
                default: begin
                  if (!in_req_i.line_sample) begin
                    if (idle_run_q < 8'(RUN_MAX)) begin
                      idle_run_d = idle_run_q + 8'd1;
                    end
                    if (idle_run_q >= idle_cnt_q) begin
                      sample_idx_d = '0;
                      phase_d      = PH_WAIT_START;
                      busy_run_d   = '0;
                    end
                  end else begin
                    idle_run_d = '0;
                    if (forced_q) begin
                      if (busy_run_q < 8'(RUN_MAX)) begin
                        busy_run_d = busy_run_q + 8'd1;
                      end
                      if (busy_run_q == idle_cnt_q) begin
                        status_d = ST_NONE;
                      end
                    end else begin
                      // line went busy without forced idle: start capture now
                      busy_run_d   = '0;
                      ram_we       = 1'b1;
                      ram_waddr    = '0;
                      sample_idx_d = CNT_W'(1);
                      phase_d      = PH_SAMPLE;
                      status_d     = ST_NONE;
                    end
                  end
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end
      TOP_CHECK: begin
        if (chk_res.done) begin
          status_d   = chk_res.ok ? ST_OK : ST_ERR;
          if (chk_res.ok) begin
            byte_d   = chk_res.data;
            byte_rdy = 1'b1;
          end
          idle_run_d = '0;
          phase_d    = PH_WAIT_IDLE;
          load_out   = 1'b1;
          state_d    = TOP_IDLE;
        end
      end
      default: begin
        state_d = TOP_IDLE;
      end
    endcase
  end

  // result register: load on a finished request, drop once taken
  always_comb begin
    out_rsp_d = out_rsp_q;
    if (load_out) begin
      out_rsp_d.frame_status  = status_d;
      out_rsp_d.byte_ready    = byte_rdy;
      out_rsp_d.received_byte = byte_d;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `OSFR_ASSERT_IMP(a_check_in_stop, clk_i, rst_ni, state_q == TOP_CHECK, phase_q == PH_STOP, "frame check outside stop phase")
  `OSFR_ASSERT_IMP(a_done_in_check, clk_i, rst_ni, chk_res.done, state_q == TOP_CHECK, "checker done without a pending check")
  `OSFR_ASSERT(a_fill_bound, clk_i, rst_ni, LW'(sample_idx_q) <= DEPTH_L, "fill count beyond store depth")
  `OSFR_ASSERT_IMP(a_no_result_in_check, clk_i, rst_ni, state_q == TOP_CHECK, !out_valid_q, "stale result during frame check")

endmodule

### src/osfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module osfr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/osfr_modadd.sv
// Shared add-and-reduce unit: (a + b) mod m for a, b below m, with wrap flag.
module osfr_modadd
  import osfr_pkg::*;
(
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic [7:0] m_i,
  output logic [7:0] sum_o,
  output logic       wrap_o
);

  logic [8:0] raw;

  assign raw    = {1'b0, a_i} + {1'b0, b_i};
  assign wrap_o = (raw >= {1'b0, m_i});
  assign sum_o  = wrap_o ? 8'(raw - {1'b0, m_i}) : raw[7:0];

endmodule

### src/osfr_check.sv
// Frame validation and byte assembly sequencer over the sample store.
`include "oversampled_serial_frame_receiver_core_assert.svh"
module osfr_check
  import osfr_pkg::*;
#(
  parameter int MAX_SAMPLE_DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [7:0]                             period_i,
  input  logic [(($clog2(MAX_SAMPLE_DEPTH+1) > 8) ?
                 $clog2(MAX_SAMPLE_DEPTH+1) : 8)-1:0] frame_len_i,
  input  logic [$clog2(MAX_SAMPLE_DEPTH+1)-1:0]  fill_i,
  output logic                                   rd_en_o,
  output logic [$clog2(MAX_SAMPLE_DEPTH)-1:0]    rd_addr_o,
  input  logic                                   rd_data_i,
  output chk_res_t                               res_o
);

  localparam int AW    = $clog2(MAX_SAMPLE_DEPTH);
  localparam int CNT_W = $clog2(MAX_SAMPLE_DEPTH + 1);
  localparam int LW    = (CNT_W > 8) ? CNT_W : 8;

  ck_state_e      state_q, state_d;
  logic [LW-1:0]  scan_q, scan_d, d_idx_q, d_idx_d;
  logic           d_vld_q, d_vld_d, d_live_q, d_live_d;
  logic           prev_q, prev_d, err_q, err_d;
  logic [7:0]     rm_q, rm_d, rc_q, rc_d, rn_q, rn_d;
  logic [3:0]     pq_q, pq_d;
  logic [4:0]     pr_q, pr_d, xr_q, xr_d;
  logic [7:0]     xq_q, xq_d;
  logic [4:0]     m_q, m_d;
  logic [2:0]     bitn_q, bitn_d;
  logic [7:0]     byte_q, byte_d;

  logic [7:0]     mu_a, mu_b, mu_m, mu_sum;
  logic           mu_wrap;
  logic [15:0]    recip_prod;
  logic [3:0]     pq_w;
  logic [7:0]     pq_x20;
  logic [LW-1:0]  fill_ext, rd_idx, round_ext;
  logic [7:0]     round_idx;
  logic           s_cur, issue, fail;

  osfr_modadd u_modadd (
    .a_i    (mu_a),
    .b_i    (mu_b),
    .m_i    (mu_m),
    .sum_o  (mu_sum),
    .wrap_o (mu_wrap)
  );

  // period / 20 by reciprocal multiply, remainder by shift-add back-multiply
  assign recip_prod = {8'd0, period_i} * 16'(RECIP_20);
  assign pq_w       = recip_prod[RECIP_SHIFT+3:RECIP_SHIFT];
  assign pq_x20     = {pq_w, 4'd0} + {2'd0, pq_w, 2'd0};

  assign fill_ext  = LW'(fill_i);
  assign s_cur     = d_live_q & rd_data_i;
  assign round_idx = 8'(xq_q + {7'd0, (xr_q > 5'(ROUND_HALF))} - 8'd1);
  assign round_ext = LW'(round_idx);
  assign issue     = (scan_q < frame_len_i);

  // error rules on the sample in the data stage
  always_comb begin
    fail = 1'b0;
    if ((d_idx_q < LW'(START_SAMPLES)) && !s_cur) begin
      fail = 1'b1;
    end
    if (((d_idx_q == frame_len_i - LW'(1)) || (d_idx_q == frame_len_i - LW'(2))) && s_cur) begin
      fail = 1'b1;
    end
    if ((d_idx_q != '0) && (s_cur != prev_q) && (rm_q > 8'(EDGE_WINDOW)) &&
        (rc_q > 8'(EDGE_WINDOW)) && (rn_q > 8'(EDGE_WINDOW))) begin
      fail = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CK_IDLE;
      d_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      d_vld_q <= d_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    d_idx_q  <= d_idx_d;
    d_live_q <= d_live_d;
    prev_q   <= prev_d;
    err_q    <= err_d;
    rm_q     <= rm_d;
    rc_q     <= rc_d;
    rn_q     <= rn_d;
    pq_q     <= pq_d;
    pr_q     <= pr_d;
    xq_q     <= xq_d;
    xr_q     <= xr_d;
    m_q      <= m_d;
    bitn_q   <= bitn_d;
    byte_q   <= byte_d;
  end

  always_comb begin
    state_d  = state_q;
    scan_d   = scan_q;
    d_idx_d  = d_idx_q;
    d_vld_d  = 1'b0;
    d_live_d = d_live_q;
    prev_d   = prev_q;
    err_d    = err_q;
    rm_d     = rm_q;
    rc_d     = rc_q;
    rn_d     = rn_q;
    pq_d     = pq_q;
    pr_d     = pr_q;
    xq_d     = xq_q;
    xr_d     = xr_q;
    m_d      = m_q;
    bitn_d   = bitn_q;
    byte_d   = byte_q;
    rd_en_o  = 1'b0;
    rd_idx   = scan_q;
    mu_a     = rn_q;
    mu_b     = 8'(SAMPLE_STEP_MS);
    mu_m     = period_i;
    res_o    = '{done: 1'b0, ok: ~err_q, data: byte_q};

    case (state_q)
      CK_IDLE: begin
        if (start_i) begin
          scan_d  = '0;
          prev_d  = 1'b0;
          err_d   = 1'b0;
          rm_d    = '0;
          rc_d    = '0;
          rn_d    = 8'(SAMPLE_STEP_MS);
          state_d = CK_SCAN;
        end
      end
      CK_SCAN: begin
        // issue one read a cycle, judge it in the cycle after
        if (issue) begin
          rd_en_o  = (scan_q < fill_ext);
          d_vld_d  = 1'b1;
          d_idx_d  = scan_q;
          d_live_d = (scan_q < fill_ext);
          scan_d   = scan_q + LW'(1);
        end
        if (d_vld_q) begin
          err_d  = err_q | fail;
          prev_d = s_cur;
          rm_d   = rc_q;
          rc_d   = rn_q;
          rn_d   = mu_sum;
        end
        if (!issue && !d_vld_q) begin
          state_d = CK_PREP;
        end
      end
      CK_PREP: begin
        pq_d   = pq_w;
        pr_d   = 5'(period_i - pq_x20);
        xq_d   = '0;
        xr_d   = '0;
        m_d    = '0;
        bitn_d = '0;
        state_d = err_q ? CK_DONE : CK_ADD;
      end
      CK_ADD: begin
        // advance x = m * period, kept as quotient and remainder of /20
        mu_a = 8'(xr_q);
        mu_b = 8'(pr_q);
        mu_m = 8'(DIV_TWENTY);
        xr_d = mu_sum[4:0];
        xq_d = 8'(xq_q + 8'(pq_q) + 8'(mu_wrap));
        m_d  = m_q + 5'd1;
        if (!m_q[0] && (m_q >= 5'd2)) begin
          state_d = CK_RD;
        end
      end
      CK_RD: begin
        rd_idx   = round_ext;
        rd_en_o  = (round_ext < fill_ext);
        d_live_d = (round_ext < fill_ext);
        state_d  = CK_BIT;
      end
      CK_BIT: begin
        byte_d = {~s_cur, byte_q[7:1]};
        bitn_d = bitn_q + 3'd1;
        state_d = (bitn_q == 3'(DATA_BITS - 1)) ? CK_DONE : CK_ADD;
      end
      CK_DONE: begin
        res_o.done = 1'b1;
        state_d    = CK_IDLE;
      end
      default: begin
        state_d = CK_IDLE;
      end
    endcase
  end

  assign rd_addr_o = AW'(rd_idx);

  `OSFR_ASSERT_IMP(a_edge_residue_reduced, clk_i, rst_ni, state_q == CK_SCAN, rn_q < period_i, "edge residue not reduced")
  `OSFR_ASSERT_IMP(a_round_rem_reduced, clk_i, rst_ni, (state_q == CK_ADD) || (state_q == CK_RD) || (state_q == CK_BIT), xr_q < 5'(DIV_TWENTY), "rounding remainder not reduced")
  `OSFR_ASSERT_IMP(a_start_when_idle, clk_i, rst_ni, start_i, state_q == CK_IDLE, "check started while busy")
  `OSFR_ASSERT_IMP(a_all_bits_built, clk_i, rst_ni, (state_q == CK_DONE) && !err_q, bitn_q == 3'd0, "byte finished with missing bits")

endmodule
